// File: sv/acs_pkg.sv
package acs_pkg;

    // Limits of the layer stack
    localparam int MAX_LAYERS  = 3;
    localparam int NUM_LANES   = 3;
    localparam int LAYER_LIMIT = (MAX_LAYERS < NUM_LANES) ? MAX_LAYERS : NUM_LANES;

    // Field widths
    localparam int C_W   = 8;
    localparam int ACT_W = 2;
    localparam int NUM_W = 2 * C_W;
    localparam int SUM_W = C_W + $clog2(NUM_LANES + 1);

    localparam logic [C_W-1:0]   FULL_COVER = 8'd255;
    localparam logic [ACT_W-1:0] ACT_RESET  = 2'd3;

    // Divider pipeline: quotient bits resolved per stage
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = C_W / BITS_PER_STAGE;
    localparam int LATENCY        = DIV_STAGES + 2;

    typedef logic [C_W-1:0] t_byte;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        t_byte            div;
    } t_lane_in;

    typedef struct packed {
        t_byte quo;
        logic  sat;
        logic  zero;
    } t_lane_out;

    typedef struct packed {
        logic valid;
        logic ovf;
    } t_ctl;

    typedef struct packed {
        t_byte part;
        logic  qbit;
    } t_step;

    // One restoring division step; expects part < div on entry
    function automatic t_step div_step(t_byte part, logic nbit, t_byte div);
        logic [C_W:0] trial;
        t_step        res;
        trial = {part, nbit};
        if (trial >= {1'b0, div}) begin
            res.part = C_W'(trial - {1'b0, div});
            res.qbit = 1'b1;
        end else begin
            res.part = trial[C_W-1:0];
            res.qbit = 1'b0;
        end
        return res;
    endfunction

endpackage

// File: sv/alpha_contribution_to_sequential_top.sv
// Sequential alpha coverage converter. Pulse start with the three layer
// contributions of a pixel; busy is always low, so a request is taken in
// every cycle that start is high. Each request yields one registered result,
// shown for a single cycle with o_valid high. The receiver cannot stall,
// so it must take every result in that cycle. Rate is one pixel per clock:
// each layer lane owns a four-stage divider that resolves two quotient bits
// per stage, and all lanes run in lockstep. The layer count register
// (i_cfg_we / i_cfg_wdata, reset 3) is sampled as a request enters, so
// write it only while no request is in flight.
module alpha_contribution_to_sequential_top
    import acs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [C_W-1:0]   i_contribution_layer1,
    input  logic [C_W-1:0]   i_contribution_layer2,
    input  logic [C_W-1:0]   i_contribution_layer3,
    input  logic             i_cfg_we,
    input  logic [ACT_W-1:0] i_cfg_wdata,
    output logic             o_valid,
    output logic [C_W-1:0]   o_coverage_layer1,
    output logic [C_W-1:0]   o_coverage_layer2,
    output logic [C_W-1:0]   o_coverage_layer3,
    output logic             o_sum_overflow
);

    logic [ACT_W-1:0] r_active_layers;

    t_byte     contrib  [NUM_LANES];
    t_lane_in  lane_in  [NUM_LANES];
    t_lane_out lane_out [NUM_LANES];
    t_byte     cov      [NUM_LANES];
    logic      front_ovf;

    // control travels alongside the divider stages
    t_ctl r_ctl [0:DIV_STAGES];
    t_ctl n_ctl [0:DIV_STAGES];

    // Never hold off a request: the pipeline advances every cycle
    assign busy = 1'b0;

    // Layer count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_layers <= ACT_RESET;
        end else if (i_cfg_we) begin
            r_active_layers <= i_cfg_wdata;
        end
    end

    assign contrib[0] = i_contribution_layer1;
    assign contrib[1] = i_contribution_layer2;
    assign contrib[2] = i_contribution_layer3;

    // Per-lane remainder, numerator and overflow check
    acs_front u_front (
        .i_contrib       (contrib),
        .i_active_layers (r_active_layers),
        .o_lane          (lane_in),
        .o_overflow      (front_ovf)
    );

    // One divider lane per layer
    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        acs_lane_div u_div (
            .i_clk    (i_clk),
            .i_lane   (lane_in[g]),
            .o_result (lane_out[g])
        );
    end

    always_comb begin
        n_ctl[0].valid = start & ~busy;
        n_ctl[0].ovf   = front_ovf;
        for (int s = 1; s <= DIV_STAGES; s++) begin
            n_ctl[s] = r_ctl[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= DIV_STAGES; s++) begin
                r_ctl[s] <= '0;
            end
        end else begin
            r_ctl <= n_ctl;
        end
    end

    // Merge lanes into the output register
    acs_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_ctl[DIV_STAGES]),
        .i_lane     (lane_out),
        .o_valid    (o_valid),
        .o_cov      (cov),
        .o_overflow (o_sum_overflow)
    );

    assign o_coverage_layer1 = cov[0];
    assign o_coverage_layer2 = cov[1];
    assign o_coverage_layer3 = cov[2];

    // A result only ever follows a request taken earlier
    a_result_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a matching request");

    // Overflow needs the full input sum to exceed full coverage
    a_overflow_needs_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sum_overflow) |->
            $past((SUM_W'(i_contribution_layer1) + SUM_W'(i_contribution_layer2)
                   + SUM_W'(i_contribution_layer3)) > SUM_W'(FULL_COVER), LATENCY))
        else $error("overflow flagged on a small sum");

    // The top layer gives no coverage when it is not in use
    a_top_layer_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_active_layers < ACT_W'(NUM_LANES))) |-> (o_coverage_layer3 == '0))
        else $error("inactive top layer produced coverage");

endmodule

// File: sv/acs_front.sv
module acs_front
    import acs_pkg::*;
(
    input  t_byte              i_contrib [NUM_LANES],
    input  logic [ACT_W-1:0]   i_active_layers,
    output t_lane_in           o_lane [NUM_LANES],
    output logic               o_overflow
);

    t_byte             c_act [NUM_LANES];
    logic [ACT_W-1:0]  layers;
    logic [SUM_W-1:0]  total;

    always_comb begin
        if (i_active_layers > ACT_W'(LAYER_LIMIT)) begin
            layers = ACT_W'(LAYER_LIMIT);
        end else begin
            layers = i_active_layers;
        end
        // drop inactive layers: a zero contribution yields a zero coverage
        for (int i = 0; i < NUM_LANES; i++) begin
            c_act[i] = (i < int'(layers)) ? i_contrib[i] : '0;
        end
        total = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            total = total + SUM_W'(c_act[i]);
        end
        o_overflow = (total > SUM_W'(FULL_COVER));
    end

    // each lane sees the coverage left over by the active layers above it
    always_comb begin
        logic [SUM_W-1:0] above;
        t_byte            rem;
        for (int i = 0; i < NUM_LANES; i++) begin
            above = '0;
            for (int j = i + 1; j < NUM_LANES; j++) begin
                above = above + SUM_W'(c_act[j]);
            end
            rem            = C_W'(SUM_W'(FULL_COVER) - above);
            o_lane[i].div  = rem;
            o_lane[i].num  = ({c_act[i], {C_W{1'b0}}} - NUM_W'(c_act[i]))
                             + NUM_W'(rem >> 1);
        end
    end

endmodule

// File: sv/acs_lane_div.sv
module acs_lane_div
    import acs_pkg::*;
(
    input  logic      i_clk,
    input  t_lane_in  i_lane,
    output t_lane_out o_result
);

    t_byte r_part [0:DIV_STAGES];
    t_byte r_low  [0:DIV_STAGES];
    t_byte r_quo  [0:DIV_STAGES];
    t_byte r_div  [0:DIV_STAGES];
    logic  r_sat  [0:DIV_STAGES];
    logic  r_zero [0:DIV_STAGES];

    t_byte n_part [0:DIV_STAGES];
    t_byte n_low  [0:DIV_STAGES];
    t_byte n_quo  [0:DIV_STAGES];
    t_byte n_div  [0:DIV_STAGES];
    logic  n_sat  [0:DIV_STAGES];
    logic  n_zero [0:DIV_STAGES];

    always_comb begin
        t_byte part;
        t_byte low;
        t_byte quo;
        t_step st;
        // load: upper half is the first partial remainder
        n_part[0] = i_lane.num[NUM_W-1:C_W];
        n_low[0]  = i_lane.num[C_W-1:0];
        n_quo[0]  = '0;
        n_div[0]  = i_lane.div;
        n_sat[0]  = (i_lane.num[NUM_W-1:C_W] >= i_lane.div);
        n_zero[0] = (i_lane.div == '0);
        for (int s = 1; s <= DIV_STAGES; s++) begin
            part = r_part[s-1];
            low  = r_low[s-1];
            quo  = r_quo[s-1];
            for (int b = 0; b < BITS_PER_STAGE; b++) begin
                st   = div_step(part, low[C_W-1], r_div[s-1]);
                part = st.part;
                low  = low << 1;
                quo  = {quo[C_W-2:0], st.qbit};
            end
            n_part[s] = part;
            n_low[s]  = low;
            n_quo[s]  = quo;
            n_div[s]  = r_div[s-1];
            n_sat[s]  = r_sat[s-1];
            n_zero[s] = r_zero[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_part <= n_part;
        r_low  <= n_low;
        r_quo  <= n_quo;
        r_div  <= n_div;
        r_sat  <= n_sat;
        r_zero <= n_zero;
    end

    always_comb begin
        o_result.quo  = r_quo[DIV_STAGES];
        o_result.sat  = r_sat[DIV_STAGES];
        o_result.zero = r_zero[DIV_STAGES];
    end

endmodule

// File: sv/acs_merge.sv
module acs_merge
    import acs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_ctl      i_ctl,
    input  t_lane_out i_lane [NUM_LANES],
    output logic      o_valid,
    output t_byte     o_cov [NUM_LANES],
    output logic      o_overflow
);

    logic  r_valid;
    logic  r_ovf;
    t_byte r_cov [NUM_LANES];
    t_byte n_cov [NUM_LANES];

    // force zeros on overflow or empty remainder, clamp on saturation
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (i_ctl.ovf || i_lane[i].zero) begin
                n_cov[i] = '0;
            end else if (i_lane[i].sat) begin
                n_cov[i] = FULL_COVER;
            end else begin
                n_cov[i] = i_lane[i].quo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf <= i_ctl.ovf;
        r_cov <= n_cov;
    end

    assign o_valid    = r_valid;
    assign o_cov      = r_cov;
    assign o_overflow = r_ovf;

endmodule
